// File: sv/mfs_pkg.sv
// Shared types and constants of the multilevel feedback scheduler.
// Used by the top level and by its port checker; depends on nothing.
package mfs_pkg;

	localparam int THREADS   = 64;
	localparam int LEVELS    = 15;
	localparam int TIME_BITS = 32;

	localparam int TID_W  = $clog2(THREADS);
	localparam int RUN_W  = TID_W + 1;
	localparam int LVL_W  = $clog2(LEVELS);
	localparam int CNT_W  = $clog2(THREADS + 1);
	localparam int PRIO_W = 4;
	localparam int TIMER_W = 20;

	localparam logic [RUN_W-1:0] IDLE_ID = RUN_W'(THREADS);
	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);

	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_WAKE   = 2'd1;
	localparam logic [1:0] MODE_YIELD  = 2'd2;

	localparam logic [2:0] CAUSE_MUTEX = 3'd1;
	localparam logic [2:0] CAUSE_IO    = 3'd2;
	localparam logic [2:0] CAUSE_USER  = 3'd4;

	localparam logic [1:0] FATE_STOPPED = 2'd1;
	localparam logic [1:0] FATE_EXITED  = 2'd2;

	localparam logic REG_BOOST   = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	localparam logic [7:0]  BOOST_RESET   = 8'd5;
	localparam logic [15:0] QUANTUM_RESET = 16'd1000;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 32;
	localparam int M_IDLE_BIT  = TID_W;
	localparam int M_TIMER_LSB = TID_W + 1;
	localparam int M_WOKEN_BIT = TID_W + 1 + TIMER_W;

	typedef enum logic [2:0] {
		ST_FREE     = 3'd0,
		ST_NEW      = 3'd1,
		ST_READY    = 3'd2,
		ST_RUNNING  = 3'd3,
		ST_STOPPED  = 3'd4,
		ST_EXITING  = 3'd5
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [PRIO_W-1:0]  prio;
		logic [PRIO_W-1:0]  saved;
		logic               cont;
		logic               timed;
	} tinfo_t;

	localparam int TINFO_W = $bits(tinfo_t);

endpackage

// File: sv/mfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependencies.
module mfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/multilevel_feedback_scheduler_top.sv
// Top level of the multilevel feedback scheduler: sequencer, ready queues and sleep list.
// Depends on mfs_pkg and mfs_ram.
//
// Channel  Direction  Handshake            Contents
// s        in         s_tvalid / s_tready  one event transaction (create, wake, yield)
// m        out        m_tvalid / m_tready  one result transaction per event
// cfg      in         cfg_we               boost period and quantum registers
//
// Create and wake events need no walk, except that removing a timed sleeper walks the sleep
// list. A yield walks the sleep list on insertion, steps through the levels in a boost pass
// and moves each nonempty level's head down, and releases expired sleepers, all set by the
// single read port of each thread table.
// Reset is asynchronous; no clearing pass is needed. A stalled result holds in the output
// register while the next event is taken.
module multilevel_feedback_scheduler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// thread_id[5:0], cause[8:6], fate[10:9], has_timeout[11], timeout_ticks[43:12],
	// now[75:44], zero fill
	input  logic [mfs_pkg::S_TDATA_W-1:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_thread[5:0], next_is_idle[6], timer_ticks[26:7], woken[27], zero fill
	output logic [mfs_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int TW = mfs_pkg::TID_W;
	localparam int LW = mfs_pkg::LVL_W;
	localparam int PW = mfs_pkg::PRIO_W;

	typedef enum logic [4:0] {
		S_IDLE, S_CW_RD, S_CW_EV, S_SR_RD, S_SR_CMP, S_MR_WR,
		S_Y_RD, S_Y_UPD, S_SI_RD, S_SI_CMP, S_SI_LNK, S_SI_LNK2,
		S_B_CHK, S_B_STEP, S_B_MOV, S_EX_RD, S_EX_CHK,
		S_SEL, S_SEL_POP, S_FIN_CUR, S_FIN_RD, S_FIN_RUN, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0]  mode_q;
	logic [TW-1:0] tid_q;
	logic [2:0]  cause_q;
	logic [1:0]  fate_q;
	logic        has_to_q;
	logic [mfs_pkg::TIME_BITS-1:0] tout_q, now_q, key_q;
	logic [7:0]  boost_q, slice_q;
	logic [15:0] quantum_q;
	logic [mfs_pkg::RUN_W-1:0] running_q, next_q;
	logic [mfs_pkg::LEVELS-1:0] nonempty_q, ne_next;
	logic [TW-1:0] head_q [mfs_pkg::LEVELS];
	logic [TW-1:0] tail_q [mfs_pkg::LEVELS];
	logic [TW-1:0] shead_q, node_q, prev_q, mr_t_q;
	logic [mfs_pkg::CNT_W-1:0] scount_q, walk_q;
	logic        prev_ok_q, cur_ready_q, woken_q, m_valid_q;
	mfs_pkg::tinfo_t  mr_ti_q;
	mfs_pkg::status_t cur_status_q;
	logic [PW-1:0] cur_prio_q;
	logic [LW-1:0] blvl_q, sel_q;
	logic [mfs_pkg::TIMER_W-1:0] timer_q;
	logic [mfs_pkg::THREADS-1:0] tv_q;
	logic [TW-1:0] tra_q;
	logic [mfs_pkg::M_TIMER_LSB+mfs_pkg::TIMER_W:0] m_data_q;

	logic          ti_we, wt_we, sl_we, ql_we;
	logic [TW-1:0] ti_wa, ti_ra, wt_wa, wt_ra, sl_wa, sl_wd, sl_ra, ql_wa, ql_ra;
	mfs_pkg::tinfo_t ti_wd, ti_rd;
	logic [mfs_pkg::TINFO_W-1:0] ti_rdata;
	logic [mfs_pkg::TIME_BITS-1:0] wt_wd, wt_rdata;
	logic [TW-1:0] sl_rdata, ql_rdata;

	logic          push_en, pop_en;
	logic [LW-1:0] push_lvl, pop_lvl, blvl_p1, sel_lvl;
	logic [TW-1:0] push_t, cur;
	logic          sel_any;

	mfs_pkg::status_t y_st;
	logic [PW-1:0] y_p, y_s;
	logic          y_c, y_timed;
	logic [TW:0]   prio_p1;
	logic [2*TW+8:0] product;
	logic          s_acc;

	assign cur     = running_q[TW-1:0];
	assign blvl_p1 = blvl_q + LW'(1);
	assign ti_rd   = tv_q[tra_q] ? mfs_pkg::tinfo_t'(ti_rdata) : mfs_pkg::tinfo_t'('0);
	assign wt_wd   = now_q + tout_q;
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign prio_p1  = {1'b0, ti_rd.prio} + (TW+1)'(1);
	assign product  = (2*TW+9)'(quantum_q) * (2*TW+9)'(prio_p1);

	always_comb begin
		sel_lvl = '0;
		for (int i = mfs_pkg::LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				sel_lvl = LW'(i);
			end
		end
		sel_any = |nonempty_q;
	end

	always_comb begin
		y_p = ti_rd.prio;
		y_s = ti_rd.saved;
		y_c = ti_rd.cont;
		if (y_c && cause_q != mfs_pkg::CAUSE_MUTEX) begin
			y_p = y_s;
			y_s = '0;
			y_c = 1'b0;
		end
		if (cause_q == mfs_pkg::CAUSE_MUTEX && !y_c) begin
			y_s = y_p;
			y_c = 1'b1;
		end
		if (cause_q <= mfs_pkg::CAUSE_MUTEX) begin
			if (y_p < PW'(mfs_pkg::LVL_MAX)) begin
				y_p = y_p + PW'(1);
			end
		end else if (cause_q inside {[mfs_pkg::CAUSE_IO:mfs_pkg::CAUSE_USER]}) begin
			if (y_p != '0) begin
				y_p = y_p - PW'(1);
			end
		end
		case (fate_q)
			mfs_pkg::FATE_STOPPED: y_st = mfs_pkg::ST_STOPPED;
			mfs_pkg::FATE_EXITED:  y_st = mfs_pkg::ST_EXITING;
			default:               y_st = mfs_pkg::ST_READY;
		endcase
		y_timed = (fate_q == mfs_pkg::FATE_STOPPED) && has_to_q;
	end

	always_comb begin
		ti_we = 1'b0; ti_wa = '0; ti_wd = '0; ti_ra = '0;
		wt_we = 1'b0; wt_wa = '0; wt_ra = '0;
		sl_we = 1'b0; sl_wa = '0; sl_wd = '0; sl_ra = '0;
		ql_ra = '0;
		push_en = 1'b0; push_lvl = '0; push_t = '0;
		pop_en = 1'b0; pop_lvl = '0;
		case (state_q)
			S_CW_RD: ti_ra = tid_q;
			S_CW_EV: begin
				if (mode_q == mfs_pkg::MODE_CREATE && ti_rd.status == mfs_pkg::ST_FREE) begin
					ti_we = 1'b1;
					ti_wa = tid_q;
					ti_wd.status = mfs_pkg::ST_NEW;
				end
			end
			S_SR_RD: sl_ra = node_q;
			S_SR_CMP: begin
				if (node_q == mr_t_q && prev_ok_q) begin
					sl_we = 1'b1;
					sl_wa = prev_q;
					sl_wd = sl_rdata;
				end
			end
			S_MR_WR: begin
				ti_we = 1'b1;
				ti_wa = mr_t_q;
				ti_wd = mr_ti_q;
				ti_wd.status = mfs_pkg::ST_READY;
				ti_wd.timed = 1'b0;
				if ({1'b0, mr_t_q} != running_q) begin
					push_en = 1'b1;
					push_lvl = LW'(mr_ti_q.prio);
					push_t = mr_t_q;
				end
			end
			S_Y_RD: ti_ra = cur;
			S_Y_UPD: begin
				ti_we = 1'b1;
				ti_wa = cur;
				ti_wd.status = y_st;
				ti_wd.prio = y_p;
				ti_wd.saved = y_s;
				ti_wd.cont = y_c;
				ti_wd.timed = y_timed;
				wt_we = y_timed;
				wt_wa = cur;
			end
			S_SI_RD: begin
				wt_ra = node_q;
				sl_ra = node_q;
			end
			S_SI_LNK: begin
				sl_we = 1'b1;
				sl_wa = cur;
				sl_wd = node_q;
			end
			S_SI_LNK2: begin
				sl_we = 1'b1;
				sl_wa = prev_q;
				sl_wd = cur;
			end
			S_B_STEP: begin
				ql_ra = head_q[blvl_p1];
				ti_ra = head_q[blvl_p1];
			end
			S_B_MOV: begin
				ti_we = 1'b1;
				ti_wa = head_q[blvl_p1];
				ti_wd = ti_rd;
				if (ti_rd.prio != '0) begin
					ti_wd.prio = ti_rd.prio - PW'(1);
				end
				pop_en = 1'b1;
				pop_lvl = blvl_p1;
				push_en = 1'b1;
				push_lvl = blvl_q;
				push_t = head_q[blvl_p1];
			end
			S_EX_RD: begin
				wt_ra = shead_q;
				sl_ra = shead_q;
				ti_ra = shead_q;
			end
			S_SEL: ql_ra = head_q[sel_lvl];
			S_SEL_POP: begin
				pop_en = 1'b1;
				pop_lvl = sel_q;
			end
			S_FIN_CUR: begin
				if (next_q != running_q && !running_q[TW]) begin
					if (cur_status_q == mfs_pkg::ST_READY) begin
						push_en = 1'b1;
						push_lvl = LW'(cur_prio_q);
						push_t = cur;
					end else if (cur_status_q == mfs_pkg::ST_EXITING) begin
						ti_we = 1'b1;
						ti_wa = cur;
					end
				end
			end
			S_FIN_RD: ti_ra = next_q[TW-1:0];
			S_FIN_RUN: begin
				ti_we = 1'b1;
				ti_wa = next_q[TW-1:0];
				ti_wd = ti_rd;
				ti_wd.status = mfs_pkg::ST_RUNNING;
			end
			default: ;
		endcase
		if (push_lvl > mfs_pkg::LVL_MAX) begin
			push_lvl = mfs_pkg::LVL_MAX;
		end
		ql_we = push_en && nonempty_q[push_lvl];
		ql_wa = tail_q[push_lvl];
		ne_next = nonempty_q;
		if (pop_en && head_q[pop_lvl] == tail_q[pop_lvl]) begin
			ne_next[pop_lvl] = 1'b0;
		end
		if (push_en) begin
			ne_next[push_lvl] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_en && head_q[pop_lvl] != tail_q[pop_lvl]) begin
			head_q[pop_lvl] <= ql_rdata;
		end
		if (push_en) begin
			if (!nonempty_q[push_lvl]) begin
				head_q[push_lvl] <= push_t;
			end
			tail_q[push_lvl] <= push_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= '0; tid_q <= '0; cause_q <= '0; fate_q <= '0; has_to_q <= 1'b0;
			tout_q <= '0; now_q <= '0; key_q <= '0;
			boost_q <= mfs_pkg::BOOST_RESET;
			quantum_q <= mfs_pkg::QUANTUM_RESET;
			slice_q <= '0;
			running_q <= mfs_pkg::IDLE_ID;
			next_q <= mfs_pkg::IDLE_ID;
			nonempty_q <= '0;
			shead_q <= '0; node_q <= '0; prev_q <= '0; mr_t_q <= '0;
			scount_q <= '0; walk_q <= '0;
			prev_ok_q <= 1'b0; cur_ready_q <= 1'b0; woken_q <= 1'b0;
			mr_ti_q <= '0;
			cur_status_q <= mfs_pkg::ST_FREE;
			cur_prio_q <= '0;
			blvl_q <= '0; sel_q <= '0;
			timer_q <= '0;
			tv_q <= '0;
			tra_q <= '0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			nonempty_q <= ne_next;
			tra_q <= ti_ra;
			if (ti_we) begin
				tv_q[ti_wa] <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					mfs_pkg::REG_BOOST:   boost_q <= cfg_wdata[7:0];
					mfs_pkg::REG_QUANTUM: quantum_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (m_valid_q && m_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						mode_q <= s_tuser;
						tid_q <= s_tdata[TW-1:0];
						cause_q <= s_tdata[8:6];
						fate_q <= s_tdata[10:9];
						has_to_q <= s_tdata[11];
						tout_q <= s_tdata[43:12];
						now_q <= s_tdata[75:44];
						woken_q <= 1'b0;
						timer_q <= '0;
						case (s_tuser)
							mfs_pkg::MODE_CREATE, mfs_pkg::MODE_WAKE: state_q <= S_CW_RD;
							mfs_pkg::MODE_YIELD: begin
								if (running_q[TW]) begin
									cur_ready_q <= 1'b1;
									state_q <= S_B_CHK;
								end else begin
									state_q <= S_Y_RD;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CW_RD: state_q <= S_CW_EV;
				S_CW_EV: begin
					if (mode_q == mfs_pkg::MODE_WAKE &&
					    ti_rd.status inside {mfs_pkg::ST_STOPPED, mfs_pkg::ST_NEW}) begin
						woken_q <= 1'b1;
						mr_t_q <= tid_q;
						mr_ti_q <= ti_rd;
						if (ti_rd.timed) begin
							node_q <= shead_q;
							prev_ok_q <= 1'b0;
							walk_q <= '0;
							state_q <= S_SR_RD;
						end else begin
							state_q <= S_MR_WR;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SR_RD: state_q <= (walk_q == scount_q) ? S_MR_WR : S_SR_CMP;
				S_SR_CMP: begin
					if (node_q == mr_t_q) begin
						if (!prev_ok_q) begin
							shead_q <= sl_rdata;
						end
						scount_q <= scount_q - mfs_pkg::CNT_W'(1);
						state_q <= S_MR_WR;
					end else begin
						prev_q <= node_q;
						prev_ok_q <= 1'b1;
						node_q <= sl_rdata;
						walk_q <= walk_q + mfs_pkg::CNT_W'(1);
						state_q <= S_SR_RD;
					end
				end
				S_MR_WR: begin
					if ({1'b0, mr_t_q} == running_q) begin
						cur_status_q <= mfs_pkg::ST_READY;
					end
					state_q <= (mode_q == mfs_pkg::MODE_YIELD) ? S_EX_RD : S_OUT;
				end
				S_Y_RD: state_q <= S_Y_UPD;
				S_Y_UPD: begin
					cur_status_q <= y_st;
					cur_prio_q <= y_p;
					cur_ready_q <= (y_st == mfs_pkg::ST_READY);
					if (y_timed) begin
						key_q <= wt_wd;
						node_q <= shead_q;
						prev_ok_q <= 1'b0;
						walk_q <= '0;
						state_q <= S_SI_RD;
					end else begin
						state_q <= S_B_CHK;
					end
				end
				S_SI_RD: state_q <= (walk_q == scount_q) ? S_SI_LNK : S_SI_CMP;
				S_SI_CMP: begin
					if (key_q < wt_rdata) begin
						state_q <= S_SI_LNK;
					end else begin
						prev_q <= node_q;
						prev_ok_q <= 1'b1;
						node_q <= sl_rdata;
						walk_q <= walk_q + mfs_pkg::CNT_W'(1);
						state_q <= S_SI_RD;
					end
				end
				S_SI_LNK: begin
					if (!prev_ok_q) begin
						shead_q <= cur;
						scount_q <= scount_q + mfs_pkg::CNT_W'(1);
						state_q <= S_B_CHK;
					end else begin
						state_q <= S_SI_LNK2;
					end
				end
				S_SI_LNK2: begin
					scount_q <= scount_q + mfs_pkg::CNT_W'(1);
					state_q <= S_B_CHK;
				end
				S_B_CHK: begin
					if (slice_q >= boost_q) begin
						slice_q <= '0;
						blvl_q <= '0;
						state_q <= S_B_STEP;
					end else begin
						state_q <= S_EX_RD;
					end
				end
				S_B_STEP: begin
					if (blvl_q == mfs_pkg::LVL_MAX) begin
						state_q <= S_EX_RD;
					end else if (nonempty_q[blvl_p1]) begin
						state_q <= S_B_MOV;
					end else begin
						blvl_q <= blvl_p1;
					end
				end
				S_B_MOV: begin
					blvl_q <= blvl_p1;
					state_q <= S_B_STEP;
				end
				S_EX_RD: state_q <= (scount_q == '0) ? S_SEL : S_EX_CHK;
				S_EX_CHK: begin
					if (wt_rdata <= now_q) begin
						mr_t_q <= shead_q;
						mr_ti_q <= ti_rd;
						shead_q <= sl_rdata;
						scount_q <= scount_q - mfs_pkg::CNT_W'(1);
						state_q <= S_MR_WR;
					end else begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					if (sel_any) begin
						sel_q <= sel_lvl;
						state_q <= S_SEL_POP;
					end else begin
						next_q <= cur_ready_q ? running_q : mfs_pkg::IDLE_ID;
						state_q <= S_FIN_CUR;
					end
				end
				S_SEL_POP: begin
					next_q <= {1'b0, head_q[sel_q]};
					state_q <= S_FIN_CUR;
				end
				S_FIN_CUR: state_q <= S_FIN_RD;
				S_FIN_RD: begin
					running_q <= next_q;
					if (slice_q != 8'hFF) begin
						slice_q <= slice_q + 8'd1;
					end
					if (next_q[TW]) begin
						timer_q <= mfs_pkg::TIMER_W'(quantum_q);
						state_q <= S_OUT;
					end else begin
						state_q <= S_FIN_RUN;
					end
				end
				S_FIN_RUN: begin
					timer_q <= product[mfs_pkg::TIMER_W-1:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q <= {woken_q, timer_q, running_q[TW],
						             running_q[TW] ? TW'(0) : running_q[TW-1:0]};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = mfs_pkg::M_TDATA_W'(m_data_q);

	mfs_ram #(.WIDTH(mfs_pkg::TINFO_W), .DEPTH(mfs_pkg::THREADS)) u_tinfo (
		.clk(clk), .we(ti_we), .waddr(ti_wa), .wdata(ti_wd),
		.raddr(ti_ra), .rdata(ti_rdata)
	);

	mfs_ram #(.WIDTH(mfs_pkg::TIME_BITS), .DEPTH(mfs_pkg::THREADS)) u_wtime (
		.clk(clk), .we(wt_we), .waddr(wt_wa), .wdata(wt_wd),
		.raddr(wt_ra), .rdata(wt_rdata)
	);

	mfs_ram #(.WIDTH(TW), .DEPTH(mfs_pkg::THREADS)) u_slink (
		.clk(clk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd),
		.raddr(sl_ra), .rdata(sl_rdata)
	);

	mfs_ram #(.WIDTH(TW), .DEPTH(mfs_pkg::THREADS)) u_qlink (
		.clk(clk), .we(ql_we), .waddr(ql_wa), .wdata(push_t),
		.raddr(ql_ra), .rdata(ql_rdata)
	);

endmodule

// File: sv/mfs_checker.sv
// Port-level checker of the multilevel feedback scheduler and its bind to the top level.
// Depends on mfs_pkg.
module mfs_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [mfs_pkg::M_TDATA_W-1:0] m_tdata
);

	// A held result keeps its contents until the transaction completes.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Each event is worked on alone, so the input closes after a transaction.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an event is in progress");

	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[mfs_pkg::M_IDLE_BIT] |-> m_tdata[mfs_pkg::TID_W-1:0] == '0)
		else $error("idle result carries a thread number");

	a_wake_timer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[mfs_pkg::M_WOKEN_BIT] |->
		m_tdata[mfs_pkg::M_TIMER_LSB +: mfs_pkg::TIMER_W] == '0)
		else $error("wake result carries a timer value");

endmodule

bind multilevel_feedback_scheduler_top mfs_checker u_mfs_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
